FILE: sv/bfle_pkg.sv
// shared types and constants of the box fill level estimator
// no dependencies; every other file imports this package
package bfle_pkg;

  // fixed-point layout
  localparam int unsigned RotFracBits = 28;
  localparam int unsigned CoefW       = 30;
  localparam int unsigned NumW        = 39;
  localparam int unsigned TallyW      = 21;
  localparam int unsigned MaxPoints   = 1048576;

  // divider sizes
  localparam int unsigned DvdW = 64;
  localparam int unsigned DvsW = 33;

  // job queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTRE_X   = 3'd0,
    REG_CENTRE_Y   = 3'd1,
    REG_CENTRE_Z   = 3'd2,
    REG_ORIENT_W   = 3'd3,
    REG_ORIENT_X   = 3'd4,
    REG_ORIENT_Y   = 3'd5,
    REG_ORIENT_Z   = 3'd6,
    REG_BOX_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [31:0] fill_level;
    logic [20:0] counted_points;
    logic        no_points;
  } result_t;

  // work passed from front to back: doubled height numerator and last flag
  typedef struct packed {
    logic signed [NumW-1:0] num;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/bfle_div.sv
// iterative unsigned divider, one quotient bit per cycle
// depends on bfle_pkg
module bfle_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfle_pkg::DvdW-1:0]  dividend_i,
  input  logic [bfle_pkg::DvsW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [bfle_pkg::DvdW-1:0]  quot_o,
  output logic [bfle_pkg::DvsW-1:0]  rem_o
);
  import bfle_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] quot_q, quot_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;

  // one restoring step
  always_comb begin
    trial  = {rem_q, quot_q[DvdW-1]};
    diff   = trial - {1'b0, dvs_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = diff[DvsW-1:0];
        quot_d = {quot_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DvsW-1:0];
        quot_d = {quot_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/bfle_queue.sv
// short job queue between front and back
// depends on bfle_pkg
module bfle_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bfle_pkg::job_t        wr_data_i,
  input  logic                  pop_i,
  output bfle_pkg::job_t        rd_data_o,
  output bfle_pkg::q_status_t   status_o
);
  import bfle_pkg::*;

  job_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == (QPtrW + 1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

FILE: sv/bfle_front.sv
// front: configuration registers, rotation coefficient update and the
// per-point rotation pipeline; depends on bfle_pkg and bfle_div
module bfle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  bfle_pkg::point_t              in_data_i,
  input  bfle_pkg::q_status_t           q_status_i,
  output logic                          q_push_o,
  output bfle_pkg::job_t                q_data_o,
  output logic [30:0]                   height_o
);
  import bfle_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_START = 3'b010,
    C_WAIT  = 3'b100
  } coef_state_e;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [15:0] ow_q, ox_q, oy_q, oz_q;
  logic [30:0]        h_q;

  coef_state_e        cst_q, cst_d;
  logic [1:0]         sel_q, sel_d;
  logic               neg_q;
  logic signed [CoefW-1:0] r0_q, r1_q, r2_q;

  logic signed [31:0] ww, xx, yy, zz, xz, wy, yz, wx;
  logic signed [33:0] n_s, num0, num1, num2, numer, numer_mag;
  logic               div_start, div_done;
  logic [DvdW-1:0]    div_quot;
  logic [DvsW-1:0]    div_rem;
  logic signed [CoefW:0] coef_new;
  logic               orient_wr;
  logic               coef_ok;

  logic signed [32:0] dx, dy, dz;
  logic signed [62:0] p0_q, p1_q, p2_q;
  logic               s1_valid_q, s1_last_q;
  logic signed [64:0] acc;
  logic signed [36:0] zr;
  logic               accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      ow_q <= 16'sd16384;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
      h_q  <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTRE_X:   cx_q <= cfg_data_i;
        REG_CENTRE_Y:   cy_q <= cfg_data_i;
        REG_CENTRE_Z:   cz_q <= cfg_data_i;
        REG_ORIENT_W:   ow_q <= cfg_data_i[15:0];
        REG_ORIENT_X:   ox_q <= cfg_data_i[15:0];
        REG_ORIENT_Y:   oy_q <= cfg_data_i[15:0];
        REG_ORIENT_Z:   oz_q <= cfg_data_i[15:0];
        REG_BOX_HEIGHT: h_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // zero height is taken as one
  assign height_o = (h_q == '0) ? 31'd1 : h_q;

  // quaternion terms for the third row of the inverse rotation
  assign ww = ow_q * ow_q;
  assign xx = ox_q * ox_q;
  assign yy = oy_q * oy_q;
  assign zz = oz_q * oz_q;
  assign xz = ox_q * oz_q;
  assign wy = ow_q * oy_q;
  assign yz = oy_q * oz_q;
  assign wx = ow_q * ox_q;

  assign n_s  = 34'(ww) + 34'(xx) + 34'(yy) + 34'(zz);
  assign num0 = (34'(xz) + 34'(wy)) <<< 1;
  assign num1 = (34'(yz) - 34'(wx)) <<< 1;
  assign num2 = 34'(ww) - 34'(xx) - 34'(yy) + 34'(zz);

  always_comb begin
    case (sel_q)
      2'd0:    numer = num0;
      2'd1:    numer = num1;
      default: numer = num2;
    endcase
    numer_mag = numer[33] ? -numer : numer;
  end

  assign orient_wr = cfg_we_i && (cfg_idx_i == REG_ORIENT_W || cfg_idx_i == REG_ORIENT_X ||
                                  cfg_idx_i == REG_ORIENT_Y || cfg_idx_i == REG_ORIENT_Z);

  assign div_start = (cst_q == C_START) && !orient_wr && (n_s != '0);

  bfle_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({2'b00, numer_mag, RotFracBits'(0)}),
    .divisor_i  (n_s[DvsW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // floor division: round a negative quotient downward
  assign coef_new = neg_q
    ? -($signed({2'b00, div_quot[CoefW-2:0]}) + $signed({{CoefW{1'b0}}, div_rem != '0}))
    :  $signed({2'b00, div_quot[CoefW-2:0]});

  // coefficient sequencer
  always_comb begin
    cst_d = cst_q;
    sel_d = sel_q;
    if (orient_wr) begin
      cst_d = C_START;
      sel_d = 2'd0;
    end else begin
      case (cst_q)
        C_IDLE: ;
        C_START: begin
          if (n_s == '0) begin
            cst_d = C_IDLE;
          end else begin
            cst_d = C_WAIT;
          end
        end
        C_WAIT: begin
          if (div_done) begin
            if (sel_q == 2'd2) begin
              cst_d = C_IDLE;
            end else begin
              sel_d = sel_q + 1'b1;
              cst_d = C_START;
            end
          end
        end
        default: cst_d = C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= C_IDLE;
      sel_q <= '0;
      neg_q <= 1'b0;
      r0_q  <= '0;
      r1_q  <= '0;
      r2_q  <= CoefW'(1 << RotFracBits);
    end else begin
      cst_q <= cst_d;
      sel_q <= sel_d;
      if (div_start) neg_q <= numer[33];
      if (cst_q == C_START && !orient_wr && n_s == '0) begin
        // zero quaternion means identity
        r0_q <= '0;
        r1_q <= '0;
        r2_q <= CoefW'(1 << RotFracBits);
      end else if (cst_q == C_WAIT && div_done && !orient_wr) begin
        case (sel_q)
          2'd0:    r0_q <= coef_new[CoefW-1:0];
          2'd1:    r1_q <= coef_new[CoefW-1:0];
          default: r2_q <= coef_new[CoefW-1:0];
        endcase
      end
    end
  end

  assign coef_ok = (cst_q == C_IDLE);

  // point accept: sequencer idle, stage one free or moving this cycle
  assign accept = coef_ok && (!s1_valid_q || !q_status_i.full);
  assign full   = !accept;

  // stage one: offset from centre and rotation products
  assign dx = $signed({in_data_i.point_x[31], in_data_i.point_x}) - $signed({cx_q[31], cx_q});
  assign dy = $signed({in_data_i.point_y[31], in_data_i.point_y}) - $signed({cy_q[31], cy_q});
  assign dz = $signed({in_data_i.point_z[31], in_data_i.point_z}) - $signed({cz_q[31], cz_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= push;
    end else if (!q_status_i.full) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      p0_q      <= r0_q * dx;
      p1_q      <= r1_q * dy;
      p2_q      <= r2_q * dz;
      s1_last_q <= in_data_i.last_point;
    end
  end

  // stage two: rotated z and doubled height numerator, into the queue
  assign acc = $signed({{2{p0_q[62]}}, p0_q}) + $signed({{2{p1_q[62]}}, p1_q})
             + $signed({{2{p2_q[62]}}, p2_q});
  assign zr  = acc[64:RotFracBits];

  assign q_data_o.num  = $signed({zr[36], zr, 1'b0}) + $signed({8'b0, height_o});
  assign q_data_o.last = s1_last_q;
  assign q_push_o      = s1_valid_q && !q_status_i.full;

endmodule

FILE: sv/bfle_back.sv
// back: height fraction, saturating sum, tally and mean result
// depends on bfle_pkg and bfle_div
module bfle_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfle_pkg::q_status_t  q_status_i,
  input  bfle_pkg::job_t       q_data_i,
  output logic                 q_pop_o,
  input  logic [30:0]          height_i,
  output logic                 empty,
  input  logic                 pop,
  output bfle_pkg::result_t    out_data_o
);
  import bfle_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_DECIDE = 6'b000010,
    B_FRAC   = 6'b000100,
    B_CHECK  = 6'b001000,
    B_MEAN   = 6'b010000,
    B_EMIT   = 6'b100000
  } back_state_e;

  back_state_e          st_q, st_d;
  logic signed [NumW-1:0] num_q;
  logic                 last_q;
  logic [63:0]          sum_q;
  logic [TallyW-1:0]    tally_q;
  result_t              res_q, out_q;
  logic                 out_valid_q;
  logic                 counts;
  logic                 start_frac, start_mean;
  logic [DvdW-1:0]      dvd;
  logic [DvsW-1:0]      dvs;
  logic                 div_done;
  logic [DvdW-1:0]      div_quot;
  logic [DvsW-1:0]      div_rem;
  logic [64:0]          sum_add;
  logic                 can_write;

  assign counts     = (num_q > 0) && (tally_q < TallyW'(MaxPoints));
  assign start_frac = (st_q == B_DECIDE) && counts;
  assign start_mean = (st_q == B_CHECK) && last_q && (tally_q != '0);
  assign can_write  = !out_valid_q || pop;
  assign q_pop_o    = (st_q == B_IDLE) && !q_status_i.empty;

  // shared divider: fraction of a point, then mean of the box
  always_comb begin
    if (st_q == B_CHECK) begin
      dvd = sum_q;
      dvs = DvsW'(tally_q);
    end else begin
      dvd = DvdW'({num_q[NumW-2:0], 15'b0});
      dvs = DvsW'(height_i);
    end
  end

  bfle_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_frac || start_mean),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign sum_add = {1'b0, sum_q} + {1'b0, div_quot};

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE:   if (!q_status_i.empty) st_d = B_DECIDE;
      B_DECIDE: st_d = counts ? B_FRAC : B_CHECK;
      B_FRAC:   if (div_done) st_d = B_CHECK;
      B_CHECK: begin
        if (!last_q) begin
          st_d = B_IDLE;
        end else if (tally_q == '0) begin
          st_d = B_EMIT;
        end else begin
          st_d = B_MEAN;
        end
      end
      B_MEAN:   if (div_done) st_d = B_EMIT;
      B_EMIT:   if (can_write) st_d = B_IDLE;
      default:  st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      sum_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_FRAC && div_done) begin
        sum_q   <= sum_add[64] ? '1 : sum_add[63:0];
        tally_q <= tally_q + 1'b1;
      end else if (st_q == B_EMIT && can_write) begin
        sum_q   <= '0;
        tally_q <= '0;
      end
      if (st_q == B_EMIT && can_write) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      num_q  <= q_data_i.num;
      last_q <= q_data_i.last;
    end
    if (st_q == B_CHECK && last_q && tally_q == '0) begin
      res_q.fill_level     <= '0;
      res_q.counted_points <= '0;
      res_q.no_points      <= 1'b1;
    end else if (st_q == B_MEAN && div_done) begin
      res_q.fill_level     <= (div_quot[63:32] != '0) ? '1 : div_quot[31:0];
      res_q.counted_points <= tally_q;
      res_q.no_points      <= 1'b0;
    end
    if (st_q == B_EMIT && can_write) begin
      out_q <= res_q;
    end
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule

FILE: sv/box_fill_level_estimator_core.sv
// top level of the box fill level estimator
// depends on bfle_pkg, bfle_front, bfle_queue and bfle_back
//
// Points are taken by the front at one a cycle while full is low, rotated into
// the box frame in a two-stage pipeline and placed in a four-entry job queue.
// The back handles one job at a time with a bit-serial divider: a point above
// the box bottom takes a division for its height fraction, any other point
// none, and the point marked last adds a division for the mean before the
// transaction is offered. A write to an orientation register recomputes the
// rotation row on its own divider in three divisions, full held high meanwhile.
module box_fill_level_estimator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  bfle_pkg::point_t     in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output bfle_pkg::result_t    out_data_o
);
  import bfle_pkg::*;

  q_status_t   q_status;
  logic        q_push, q_pop;
  job_t        q_wr, q_rd;
  logic [30:0] height;

  bfle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_wr),
    .height_o   (height)
  );

  bfle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr),
    .pop_i     (q_pop),
    .rd_data_o (q_rd),
    .status_o  (q_status)
  );

  bfle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_data_i   (q_rd),
    .q_pop_o    (q_pop),
    .height_i   (height),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule

FILE: dv/box_fill_level_estimator_core_tb.sv
// self-checking testbench for box_fill_level_estimator_core
// depends on bfle_pkg and the block's RTL; directed table first, then random points
module box_fill_level_estimator_core_tb;
  import bfle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        last;
    bit          fixed;   // result typed in below
    result_t     res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  point_t      in_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     out_data_o;

  // shadow of the box configuration and accumulator
  logic signed [31:0] sh_cx, sh_cy, sh_cz;
  logic signed [15:0] sh_qw, sh_qx, sh_qy, sh_qz;
  logic [30:0]        sh_h;
  logic [63:0]        sh_sum;
  logic [20:0]        sh_tally;

  result_t     fill_expect_q[$];
  int unsigned err_cnt = 0;
  longint      cyc = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;

  box_fill_level_estimator_core DUT (.*);

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // rotate the point into the box frame and accumulate; result on a last point
  function automatic bit fill_predict(input point_t p, output result_t r);
    longint w, x, y, z, n, hh, r0, r1, r2, acc, zr, num;
    logic [63:0] frac, mean;
    w = sh_qw; x = sh_qx; y = sh_qy; z = sh_qz;
    n = w*w + x*x + y*y + z*z;
    hh = (sh_h == 0) ? 1 : longint'(sh_h);
    if (n == 0) begin
      r0 = 0; r1 = 0; r2 = longint'(1) << 28;
    end else begin
      r0 = fdiv(2*(x*z + w*y) * (longint'(1) << 28), n);
      r1 = fdiv(2*(y*z - w*x) * (longint'(1) << 28), n);
      r2 = fdiv((w*w - x*x - y*y + z*z) * (longint'(1) << 28), n);
    end
    acc = r0*(longint'(p.point_x) - sh_cx) + r1*(longint'(p.point_y) - sh_cy)
        + r2*(longint'(p.point_z) - sh_cz);
    zr = fdiv(acc, longint'(1) << 28);
    num = 2*zr + hh;
    if (num > 0 && sh_tally < MaxPoints) begin
      frac = (64'(num) * 64'd32768) / 64'(hh);
      sh_sum = (sh_sum > ~frac) ? '1 : sh_sum + frac;
      sh_tally++;
    end
    r = '0;
    if (!p.last_point) return 1'b0;
    if (sh_tally == 0) r.no_points = 1'b1;
    else begin
      mean = sh_sum / 64'(sh_tally);
      r.fill_level = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      r.counted_points = sh_tally;
    end
    sh_sum = '0;
    sh_tally = '0;
    return 1'b1;
  endfunction

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_CENTRE_X:   sh_cx = val;
      REG_CENTRE_Y:   sh_cy = val;
      REG_CENTRE_Z:   sh_cz = val;
      REG_ORIENT_W:   sh_qw = val[15:0];
      REG_ORIENT_X:   sh_qx = val[15:0];
      REG_ORIENT_Y:   sh_qy = val[15:0];
      REG_ORIENT_Z:   sh_qz = val[15:0];
      REG_BOX_HEIGHT: sh_h  = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_box(input logic [31:0] cx, cy, cz, input logic [15:0] qw, qx, qy, qz,
                         input logic [30:0] h);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_CENTRE_Z, cz);
    write_reg(REG_ORIENT_W, {{16{qw[15]}}, qw});
    write_reg(REG_ORIENT_X, {{16{qx[15]}}, qx});
    write_reg(REG_ORIENT_Y, {{16{qy[15]}}, qy});
    write_reg(REG_ORIENT_Z, {{16{qz[15]}}, qz});
    write_reg(REG_BOX_HEIGHT, {1'b0, h});
    cfg_we_i <= 1'b0;
  endtask

  // wait for every result, then let trailing non-result points drain
  task automatic drain_idle();
    push <= 1'b0;
    while (fill_expect_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // offer one point, hold until taken
  task automatic send_point(input point_t p, input bit fixed, input result_t fixed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (full);
    if (fill_predict(p, r)) begin
      if (fixed && r !== fixed_res) report_mismatch("typed-in result differs from prediction");
      fill_expect_q.push_back(fixed ? fixed_res : r);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic point_t rand_point(input int unsigned last_pct);
    point_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = rand_coord();
    p.last_point = ($urandom_range(99) < last_pct);
    return p;
  endfunction

  // result side: pop with random idling, check against oldest expectation
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (fill_expect_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        result_t e;
        e = fill_expect_q.pop_front();
        if (out_data_o.fill_level !== e.fill_level)
          report_mismatch($sformatf("fill_level %h exp %h", out_data_o.fill_level,
                                    e.fill_level));
        if (out_data_o.counted_points !== e.counted_points)
          report_mismatch($sformatf("counted_points %0d exp %0d",
                                    out_data_o.counted_points, e.counted_points));
        if (out_data_o.no_points !== e.no_points)
          report_mismatch($sformatf("no_points %b exp %b", out_data_o.no_points,
                                    e.no_points));
      end
    end
    pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  dir_row_t dir_tab[$];

  function automatic dir_row_t row(input logic [31:0] x, y, z, input logic l,
                                   input bit fx = 0, input result_t r = '0);
    dir_row_t d;
    d.px = x; d.py = y; d.pz = z; d.last = l; d.fixed = fx; d.res = r;
    return d;
  endfunction

  initial begin
    point_t p;
    result_t none;
    none = '0;
    sh_cx = 0; sh_cy = 0; sh_cz = 0;
    sh_qw = 16384; sh_qx = 0; sh_qy = 0; sh_qz = 0;
    sh_h = 65536; sh_sum = 0; sh_tally = 0;

    // directed points, reset configuration (identity, height 1 m)
    dir_tab.push_back(row(0, 0, 32'hFFFF_8000, 1, 1, '{0, 0, 1}));  // on bottom: empty box
    dir_tab.push_back(row(0, 0, 0, 1, 1, '{32'h8000, 1, 0}));        // centre: half full
    dir_tab.push_back(row(0, 0, 32'h8000, 1, 1, '{32'h10000, 1, 0}));// top
    dir_tab.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    dir_tab.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    dir_tab.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    dir_tab.push_back(row(0, 0, 32'hFFFF_8001, 1));
    dir_tab.push_back(row(32'h1234_5678, 32'hEDCB_A987, 32'h0000_4000, 0));
    dir_tab.push_back(row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 1));

    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      p.point_x = dir_tab[i].px; p.point_y = dir_tab[i].py;
      p.point_z = dir_tab[i].pz; p.last_point = dir_tab[i].last;
      send_point(p, dir_tab[i].fixed, dir_tab[i].res);
    end
    drain_idle();

    // extreme settings: zero quaternion, zero height, max height, big offsets
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_point(rand_point(30), 0, none);
    p = '0; p.point_z = 32'h7FFF_FFFF; p.last_point = 1; send_point(p, 0, none);
    drain_idle();
    set_box(0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_point(rand_point(30), 0, none);
    p = '0; p.last_point = 1; send_point(p, 0, none);
    drain_idle();
    // tiny height gives huge fractions, saturating the mean
    set_box(32'h8000_0000, 0, 32'h8000_0000, 16384, 0, 0, 0, 1);
    for (int i = 0; i < 4; i++) begin
      p = '0; p.point_z = 32'h7FFF_FFFF; p.last_point = (i == 3); send_point(p, 0, none);
    end
    drain_idle();

    // random phases with changing idling profiles and box settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 13 : 0;
      for (int b = 0; b < 3; b++) begin
        set_box(rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192)),
                16'($urandom), 16'($urandom_range(0, 4096)), 16'($urandom),
                $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1, 4 * 65536)));
        for (int i = 0; i < 50; i++) send_point(rand_point(15), 0, none);
        p = rand_point(100); send_point(p, 0, none);
        drain_idle();
      end
    end

    // hold the receiver so the block fills and stalls its input
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_point(rand_point(50), 0, none);
    join
    push <= 1'b0;
    while (fill_expect_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
